// ===== rtl/hpt_pkg.sv =====
package hpt_pkg;

  // item opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  // depth of the queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // depth of the result queue
  localparam int ODEPTH = 2;

  // divider lanes (x, y, z) and quotient bits
  localparam int LANES = 3;
  localparam int QBITS = 32;

  // one transform job with its snapshot of the matrix
  typedef struct packed {
    logic [31:0]       x;
    logic [31:0]       y;
    logic [31:0]       z;
    logic [15:0][31:0] m;
  } hpt_job_t;

  // sideband that rides along the divider
  typedef struct packed {
    logic                   wz;
    logic                   wone;
    logic                   sat;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       ovf;
    logic [LANES-1:0][31:0] raw;
  } hpt_side_t;

  // one result beat
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } hpt_res_t;

endpackage

// ===== rtl/hpt_front.sv =====
module hpt_front import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_opcode,
  input  logic [3:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic               deq,
  output logic               job_valid,
  output hpt_job_t           job
);

  logic [15:0][31:0] matrix_r;
  hpt_job_t          q_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QAW:0]      cnt_r, cnt_nxt;
  logic              acc, enq, pop_q;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign acc       = push && !full;
  assign enq       = acc && (in_opcode == OP_XFORM);
  assign job_valid = (cnt_r != '0);
  assign pop_q     = deq && job_valid;
  assign job       = q_r[rd_ptr_r];

  // write a coefficient on a load beat, identity after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        matrix_r[i] <= (i % 5 == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
      end
    end else if (acc && (in_opcode == OP_LOAD)) begin
      matrix_r[in_coeff_index] <= in_coeff_value;
    end
  end

  // queue a transform with the matrix it sees
  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= '{x: in_x, y: in_y, z: in_z, m: matrix_r};
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq && !pop_q) cnt_nxt = cnt_r + 1'b1;
    else if (!enq && pop_q) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (enq) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop_q) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count over depth");
  a_load_no_enq: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_opcode == OP_LOAD) |=> cnt_r <= $past(cnt_r))
    else $error("load beat grew queue");
  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop_q |=> full) else $error("full queue changed without pop");
`endif

endmodule

// ===== rtl/hpt_divider.sv =====
module hpt_divider import hpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_v,
  input  logic [LANES-1:0][31:0] in_rem,
  input  logic [LANES-1:0][31:0] in_low,
  input  logic [31:0]            in_d,
  input  hpt_side_t              in_side,
  output logic                   out_v,
  output logic [LANES-1:0][31:0] out_q,
  output hpt_side_t              out_side
);

  logic                   v_r    [QBITS];
  logic [LANES-1:0][31:0] rem_r  [QBITS];
  logic [LANES-1:0][31:0] low_r  [QBITS];
  logic [LANES-1:0][31:0] q_r    [QBITS];
  logic [31:0]            d_r    [QBITS];
  hpt_side_t              side_r [QBITS];

  // one quotient bit per stage, restoring
  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    logic                   v_i;
    logic [LANES-1:0][31:0] rem_i, low_i, q_i, rem_o, q_o;
    logic [31:0]            d_i;
    hpt_side_t              side_i;
    logic [LANES-1:0][32:0] trial;

    if (s == 0) begin : g_first
      assign v_i    = in_v;
      assign rem_i  = in_rem;
      assign low_i  = in_low;
      assign q_i    = '0;
      assign d_i    = in_d;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign low_i  = low_r[s-1];
      assign q_i    = q_r[s-1];
      assign d_i    = d_r[s-1];
      assign side_i = side_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {rem_i[l], low_i[l][31]};
        if (trial[l] >= {1'b0, d_i}) begin
          rem_o[l] = 32'(trial[l] - {1'b0, d_i});
          q_o[l]   = {q_i[l][30:0], 1'b1};
        end else begin
          rem_o[l] = trial[l][31:0];
          q_o[l]   = {q_i[l][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (adv) v_r[s] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_o;
        for (int l = 0; l < LANES; l++) low_r[s][l] <= {low_i[l][30:0], 1'b0};
        q_r[s]    <= q_o;
        d_r[s]    <= d_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_v    = v_r[QBITS-1];
  assign out_q    = q_r[QBITS-1];
  assign out_side = side_r[QBITS-1];

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(out_v) && $stable(out_q)) else $error("divider moved on stall");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_v |=> v_r[0]) else $error("divider dropped a beat");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v && !out_side.ovf[0] && d_r[QBITS-1] != '0 |-> rem_r[QBITS-1][0] < d_r[QBITS-1])
    else $error("remainder not below divisor");
`endif

endmodule

// ===== rtl/hpt_back.sv =====
module hpt_back import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  hpt_job_t           job,
  output logic               deq,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_w_zero,
  output logic               out_saturated
);

  localparam logic signed [66:0] MAXV = 67'sd2147483647;
  localparam logic signed [66:0] MINV = -67'sd2147483648;

  logic adv;

  // result queue state
  hpt_res_t          oq_r [ODEPTH];
  logic              owr_r, ord_r;
  logic [1:0]        ocnt_r, ocnt_nxt;
  logic              owr, ord;

  // stage 1: products
  logic                     s1_v_r;
  logic signed [3:0][2:0][63:0] s1_p_r;
  logic [3:0][31:0]         s1_t_r;
  // stage 2: three-term sums
  logic                     s2_v_r;
  logic signed [3:0][65:0]  s2_s_r;
  logic [3:0][31:0]         s2_t_r;
  // stage 3: floored, offset, clamped rows
  logic                     s3_v_r;
  logic [3:0][31:0]         s3_r_r;
  logic                     s3_sat_r;
  // stage 4: divider setup
  logic                     s4_v_r;
  logic [LANES-1:0][31:0]   s4_rem_r, s4_low_r;
  logic [31:0]              s4_d_r;
  hpt_side_t                s4_side_r;

  logic signed [3:0][65:0]  sum3;
  logic [3:0][31:0]         rows;
  logic                     rsat;
  logic signed [66:0]       h;
  logic [LANES-1:0][31:0]   un, rem0, low0;
  logic [31:0]              ud;
  hpt_side_t                side0;

  logic                     dv;
  logic [LANES-1:0][31:0]   dq;
  hpt_side_t                dside;
  hpt_res_t                 res;

  // stall the whole back end only when results back up
  assign adv = (ocnt_r != 2'(ODEPTH));
  assign deq = adv;

  // multiply each matrix column by its coordinate
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= job_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        s1_p_r[r][0] <= $signed(job.m[r])     * $signed(job.x);
        s1_p_r[r][1] <= $signed(job.m[4 + r]) * $signed(job.y);
        s1_p_r[r][2] <= $signed(job.m[8 + r]) * $signed(job.z);
        s1_t_r[r]    <= job.m[12 + r];
      end
    end
  end

  // add the three exact products of each row
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum3[r] = 66'($signed(s1_p_r[r][0])) + 66'($signed(s1_p_r[r][1]))
              + 66'($signed(s1_p_r[r][2]));
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s_r <= sum3;
      s2_t_r <= s1_t_r;
    end
  end

  // floor to the fixed point, add translation, clamp to 32 bits
  always_comb begin
    rsat = 1'b0;
    h    = '0;
    for (int r = 0; r < 4; r++) begin
      h = 67'($signed(s2_s_r[r]) >>> FRAC_BITS) + 67'($signed(s2_t_r[r]));
      if (h > MAXV) begin
        rows[r] = 32'h7fff_ffff;
        rsat    = 1'b1;
      end else if (h < MINV) begin
        rows[r] = 32'h8000_0000;
        rsat    = 1'b1;
      end else begin
        rows[r] = h[31:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r_r   <= rows;
      s3_sat_r <= rsat;
    end
  end

  // take magnitudes and signs, flag quotients that overflow 32 bits
  always_comb begin
    ud = s3_r_r[3][31] ? (~s3_r_r[3] + 32'd1) : s3_r_r[3];
    side0.wz   = (s3_r_r[3] == '0);
    side0.wone = (s3_r_r[3] == (32'd1 << FRAC_BITS));
    side0.sat  = s3_sat_r;
    for (int l = 0; l < LANES; l++) begin
      un[l]          = s3_r_r[l][31] ? (~s3_r_r[l] + 32'd1) : s3_r_r[l];
      side0.neg[l]   = s3_r_r[l][31] ^ s3_r_r[3][31];
      rem0[l]        = un[l] >> (32 - FRAC_BITS);
      low0[l]        = un[l] << FRAC_BITS;
      side0.ovf[l]   = (rem0[l] >= ud);
      side0.raw[l]   = s3_r_r[l];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_rem_r  <= rem0;
      s4_low_r  <= low0;
      s4_d_r    <= ud;
      s4_side_r <= side0;
    end
  end

  hpt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (s4_v_r),
    .in_rem   (s4_rem_r),
    .in_low   (s4_low_r),
    .in_d     (s4_d_r),
    .in_side  (s4_side_r),
    .out_v    (dv),
    .out_q    (dq),
    .out_side (dside)
  );

  // sign and saturate quotients, or bypass on w of zero or one
  always_comb begin
    logic [LANES-1:0][31:0] fin;
    logic                   qsat;
    qsat = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (dside.neg[l]) begin
        if (dside.ovf[l] || dq[l] > 32'h8000_0000) begin
          fin[l] = 32'h8000_0000;
          qsat   = 1'b1;
        end else begin
          fin[l] = ~dq[l] + 32'd1;
        end
      end else begin
        if (dside.ovf[l] || dq[l][31]) begin
          fin[l] = 32'h7fff_ffff;
          qsat   = 1'b1;
        end else begin
          fin[l] = dq[l];
        end
      end
    end
    res.wz = dside.wz;
    if (dside.wz) begin
      res.x   = '0;
      res.y   = '0;
      res.z   = '0;
      res.sat = dside.sat;
    end else if (dside.wone) begin
      res.x   = dside.raw[0];
      res.y   = dside.raw[1];
      res.z   = dside.raw[2];
      res.sat = dside.sat;
    end else begin
      res.x   = fin[0];
      res.y   = fin[1];
      res.z   = fin[2];
      res.sat = dside.sat | qsat;
    end
  end

  // result queue
  assign owr   = dv && adv;
  assign empty = (ocnt_r == '0);
  assign ord   = pop && !empty;

  always_ff @(posedge clk) begin
    if (owr) oq_r[owr_r] <= res;
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (owr && !ord) ocnt_nxt = ocnt_r + 1'b1;
    else if (!owr && ord) ocnt_nxt = ocnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (owr) owr_r <= ~owr_r;
      if (ord) ord_r <= ~ord_r;
      ocnt_r <= ocnt_nxt;
    end
  end

  assign out_x         = oq_r[ord_r].x;
  assign out_y         = oq_r[ord_r].y;
  assign out_z         = oq_r[ord_r].z;
  assign out_w_zero    = oq_r[ord_r].wz;
  assign out_saturated = oq_r[ord_r].sat;

`ifndef NO_ASSERTIONS
  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 2'(ODEPTH)) else $error("result queue over depth");
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_w_zero |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("w zero result not cleared");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_v_r) && $stable(s4_v_r)) else $error("pipeline moved on stall");
`endif

endmodule

// ===== rtl/homogeneous_point_transform.sv =====
// Path from an accepted transform beat to its result on the out ports:
// the job queue, four arithmetic stages, the 32-stage divider and the result queue.
// Throughput: one beat per cycle unless full; a load acts at once, with no result.
// Reset (rst_n low, synchronous): matrix returns to identity, both queues empty.
module homogeneous_point_transform import hpt_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_opcode,
  input  logic [3:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_w_zero,
  output logic               out_saturated
);

  logic     job_valid, deq;
  hpt_job_t job;

  hpt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_opcode      (in_opcode),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .deq            (deq),
    .job_valid      (job_valid),
    .job            (job)
  );

  hpt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (job_valid),
    .job           (job),
    .deq           (deq),
    .empty         (empty),
    .pop           (pop),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w_zero    (out_w_zero),
    .out_saturated (out_saturated)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import hpt_pkg::*;

  localparam int FRAC = 16;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC;
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic in_opcode = OP_LOAD;
  logic [3:0] in_coeff_index = '0;
  logic signed [31:0] in_coeff_value = '0;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_w_zero, out_saturated;

  homogeneous_point_transform u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_opcode(in_opcode), .in_coeff_index(in_coeff_index),
    .in_coeff_value(in_coeff_value), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .empty(empty), .pop(pop), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_w_zero(out_w_zero), .out_saturated(out_saturated)
  );

  always #6 clk = ~clk;

  logic [31:0] mat [16];
  hpt_res_t expected_points[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit rx_gaps = 1'b1;

  // set the matrix copy to identity
  function automatic void mat_identity();
    for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'(ONE_Q) : 32'd0;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               inout bit sat);
    if (v > MAXV) begin sat = 1; return MAXV; end
    if (v < MINV) begin sat = 1; return MINV; end
    return v;
  endfunction

  // row r of the matrix times (x, y, z, 1), floor shift, clamp
  function automatic logic signed [63:0] row_dot(input int r, input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] z, inout bit sat);
    logic signed [95:0] acc;
    acc = (96'(signed'(mat[r])) * 96'(x) + 96'(signed'(mat[4+r])) * 96'(y)
          + 96'(signed'(mat[8+r])) * 96'(z)) >>> FRAC;
    acc = acc + 96'(signed'(mat[12+r]));
    if (acc > 96'(MAXV)) begin sat = 1; return MAXV; end
    if (acc < 96'(MINV)) begin sat = 1; return MINV; end
    return 64'(acc);
  endfunction

  // (n << FRAC) / d toward zero, clamped
  function automatic logic signed [63:0] q_div(input logic signed [63:0] n,
      input logic signed [63:0] d, inout bit sat);
    logic signed [63:0] q;
    q = (n <<< FRAC) / d;
    return clamp(q, sat);
  endfunction

  // apply one beat to the predictor
  function automatic void predict(input logic op, input logic [3:0] idx,
      input logic [31:0] val, input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z);
    hpt_res_t r;
    logic signed [63:0] tx, ty, tz, tw;
    bit sat;
    if (op == OP_LOAD) begin
      mat[idx] = val;
      return;
    end
    sat = 0;
    tx = row_dot(0, x, y, z, sat);
    ty = row_dot(1, x, y, z, sat);
    tz = row_dot(2, x, y, z, sat);
    tw = row_dot(3, x, y, z, sat);
    r.wz = 0;
    if (tw == 0) begin
      r.wz = 1; tx = 0; ty = 0; tz = 0;
    end else if (tw != ONE_Q) begin
      tx = q_div(tx, tw, sat);
      ty = q_div(ty, tw, sat);
      tz = q_div(tz, tw, sat);
    end
    r.x = tx[31:0]; r.y = ty[31:0]; r.z = tz[31:0]; r.sat = sat;
    expected_points.push_back(r);
  endfunction

  // offer one beat and wait for it to be taken
  task automatic send_beat(input logic op, input logic [3:0] idx, input logic [31:0] val,
      input logic [31:0] x, input logic [31:0] y, input logic [31:0] z, input int gap);
    push <= 1'b1;
    in_opcode <= op; in_coeff_index <= idx; in_coeff_value <= val;
    in_x <= x; in_y <= y; in_z <= z;
    do @(posedge clk); while (full);
    predict(op, idx, val, x, y, z);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load(input logic [3:0] idx, input logic [31:0] val);
    send_beat(OP_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom_range(0, 10));
  endtask

  task automatic xform(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    send_beat(OP_XFORM, 4'($urandom), $urandom, x, y, z, $urandom_range(0, 10));
  endtask

  // hold the input until every expected result is back
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  function automatic logic [31:0] rnd_coeff();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'(ONE_Q) * $urandom_range(0, 4);
      2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      3: return 32'h8000_0000;
      default: return $urandom_range(0, 2) ? 32'h7fff_ffff : 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] rnd_coord();
    return $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 32'h20_0000) - 32'h10_0000);
  endfunction

  task automatic test_identity_extremes();
    xform(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    xform(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    xform(32'h0001_0000, 32'hfffe_0000, 32'h0003_8000);
    drain();
  endtask

  task automatic test_w_cases();
    // w zero
    load(4'd15, 32'd0);
    xform(32'h0005_0000, 32'h0002_0000, 32'h0001_0000);
    // w from z: perspective divide, negative and tiny w
    load(4'd11, 32'h0001_0000);
    xform(32'h0006_0000, 32'hfffa_0000, 32'h0002_0000);
    xform(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    xform(32'h0000_0001, 32'h0003_0000, 32'hfffe_8000);
    // sum overflow
    load(4'd0, 32'h7fff_ffff);
    load(4'd12, 32'h7fff_ffff);
    xform(32'h7fff_ffff, 32'h0, 32'h0001_0000);
    xform(32'h8000_0000, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_random();
    for (int n = 0; n < 500; n++) begin
      if ($urandom_range(0, 3) == 0) load(4'($urandom), rnd_coeff());
      else xform(rnd_coord(), rnd_coord(), rnd_coord());
      if (n == 200) rx_gaps = 1'b0;
      if (n == 300) rx_gaps = 1'b1;
      if (n == 400) drain();
    end
    drain();
  endtask

  // keep offering back to back while the receiver holds off, so the input stalls
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int n = 0; n < 80; n++)
      send_beat(OP_XFORM, '0, '0, rnd_coord(), rnd_coord(), rnd_coord(), 0);
    drain();
  endtask

  // receiver: draw a stall per beat, hold off once when asked
  initial begin
    int wait_cycles;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_cycles = rx_gaps ? $urandom_range(0, 10) : 0;
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // check each popped beat against the oldest expectation
  always @(posedge clk) begin
    hpt_res_t e;
    if (rst_n && pop && !empty) begin
      if (expected_points.size() == 0) begin
        $error("unexpected result x=%h y=%h z=%h", out_x, out_y, out_z);
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (out_x !== e.x) begin $error("out_x exp %h got %h", e.x, out_x); errors++; end
        if (out_y !== e.y) begin $error("out_y exp %h got %h", e.y, out_y); errors++; end
        if (out_z !== e.z) begin $error("out_z exp %h got %h", e.z, out_z); errors++; end
        if (out_w_zero !== e.wz) begin
          $error("out_w_zero exp %b got %b", e.wz, out_w_zero); errors++;
        end
        if (out_saturated !== e.sat) begin
          $error("out_saturated exp %b got %b", e.sat, out_saturated); errors++;
        end
      end
    end
  end

  initial begin
    mat_identity();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_extremes();
    test_w_cases();
    test_backpressure();
    test_random();
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_points.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 200000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== homogeneous_point_transform.f =====
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_divider.sv
rtl/hpt_back.sv
rtl/homogeneous_point_transform.sv
sim/tb.sv
